@@ src/life_like_automaton_grid_step_core_assert.svh @@
// Assertion macros shared by the grid step core.
// Each macro expects signals named clk and rst in the including module.
`ifndef LIFE_LIKE_AUTOMATON_GRID_STEP_CORE_ASSERT_SVH
`define LIFE_LIKE_AUTOMATON_GRID_STEP_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define LLAG_ASSERT_IMPL(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LLAG_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) else $error(msg);

`endif

@@ src/llag_pkg.sv @@
// Shared constants, codes and request types of the grid step core.
// No dependencies; every other file but the result interface and the assertion header uses it.
package llag_pkg;

  // Grid geometry.
  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 64;
  localparam int COL_W       = $clog2(GRID_WIDTH);
  localparam int ROW_W       = $clog2(GRID_HEIGHT);

  // Field widths of the channels.
  localparam int OP_W       = 2;
  localparam int POS_W      = 6;
  localparam int MASK_W     = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CNT_W      = 4;

  // Register reset values.
  localparam logic [MASK_W-1:0] BIRTH_RESET   = 9'd8;
  localparam logic [MASK_W-1:0] SURVIVE_RESET = 9'd12;

  // Operation codes; the unused code behaves as a read.
  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_ADVANCE = 2'd2
  } op_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BIRTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SURVIVE = 2'd1;

  // Row read request to one bank.
  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] addr;
  } rd_req_t;

  // Row write request to one bank, with a per-cell write enable.
  typedef struct packed {
    logic                  en;
    logic [ROW_W-1:0]      addr;
    logic [GRID_WIDTH-1:0] data;
    logic [GRID_WIDTH-1:0] mask;
  } wr_req_t;

endpackage

@@ src/llag_cmd_if.sv @@
// Command channel of the grid step core: op, cell position and write value.
// Depends on llag_pkg for the field widths.
interface llag_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [llag_pkg::OP_W-1:0]  op;
  logic [llag_pkg::POS_W-1:0] col;
  logic [llag_pkg::POS_W-1:0] row;
  logic                       alive_in;

  modport source (output valid, output op, output col, output row, output alive_in,
                  input ready);
  modport sink   (input valid, input op, input col, input row, input alive_in,
                  output ready);
endinterface

@@ src/llag_result_if.sv @@
// Result channel of the grid step core: one cell value per command.
// Has no dependencies.
interface llag_result_if;
  logic valid;
  logic ready;
  logic alive_out;

  modport source (output valid, output alive_out, input ready);
  modport sink   (input valid, input alive_out, output ready);
endinterface

@@ src/llag_cfg_if.sv @@
// Configuration write channel of the grid step core: register index and data.
// Depends on llag_pkg for the field widths.
interface llag_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [llag_pkg::CFG_IDX_W-1:0] index;
  logic [llag_pkg::MASK_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/llag_bank.sv @@
// One grid bank: a row-wide memory with per-cell write enables and row valid bits.
// Depends on llag_pkg for the geometry and the request structs.
module llag_bank (
  input  logic                            clk,
  input  logic                            rst,
  input  llag_pkg::rd_req_t               rd,
  input  llag_pkg::wr_req_t               wr,
  output logic [llag_pkg::GRID_WIDTH-1:0] rdata
);
  import llag_pkg::*;

  logic [GRID_WIDTH-1:0]  mem [GRID_HEIGHT];
  logic [GRID_HEIGHT-1:0] row_valid;
  logic [GRID_WIDTH-1:0]  rdata_raw;
  logic                   rvalid;
  logic [GRID_WIDTH-1:0]  wr_mask_eff;

  // A row never written holds garbage, so its first write stores the whole row.
  assign wr_mask_eff = row_valid[wr.addr] ? wr.mask : '1;

  // Row valid bits, cleared at reset so the bank reads as all dead.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr.en) begin
      row_valid[wr.addr] <= 1'b1;
    end
  end

  // Memory write with per-cell enables.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      for (int i = 0; i < GRID_WIDTH; i++) begin
        if (wr_mask_eff[i]) begin
          mem[wr.addr][i] <= wr.data[i];
        end
      end
    end
  end

  // Registered row read; the valid bit travels with the data.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata_raw <= mem[rd.addr];
      rvalid    <= row_valid[rd.addr];
    end
  end

  assign rdata = rvalid ? rdata_raw : '0;

endmodule

@@ src/llag_rule.sv @@
// Neighbor count and birth/survive decision for one cell of a 3x3 window.
// Depends on llag_pkg for the mask and count widths.
module llag_rule (
  input  logic [2:0]                  win_top,
  input  logic [2:0]                  win_mid,
  input  logic [2:0]                  win_bot,
  input  logic [llag_pkg::MASK_W-1:0] birth_mask,
  input  logic [llag_pkg::MASK_W-1:0] survive_mask,
  output logic                        alive_next
);
  import llag_pkg::*;

  logic [CNT_W-1:0] count;

  // Count the eight neighbors; the center cell is excluded.
  always_comb begin
    count = CNT_W'(win_top[0]) + CNT_W'(win_top[1]) + CNT_W'(win_top[2])
          + CNT_W'(win_mid[0]) + CNT_W'(win_mid[2])
          + CNT_W'(win_bot[0]) + CNT_W'(win_bot[1]) + CNT_W'(win_bot[2]);
  end

  // A live center looks up the survive mask, a dead one the birth mask.
  assign alive_next = win_mid[1] ? survive_mask[count] : birth_mask[count];

endmodule

@@ src/life_like_automaton_grid_step_core.sv @@
// Life-like cellular automaton grid with a birth/survive rule.
// Channels: cmd (sink) takes op, col, row and alive_in; result (source) returns
// alive_out, exactly one beat per command beat; cfg (sink) writes birth_mask
// (index 0) and survive_mask (index 1), always ready, ignored at other indexes.
// A write command stores one cell of the current bank and answers in the same
// edge that takes the beat. A read answers in the cycle after its beat: the row
// read from the bank memory starts with the beat, then the cell select. An
// advance sweeps every cell once through one shared neighbor/rule unit, one
// cell per cycle, over a three-row window that is fed by one bank read per row.
// The block takes one command at a time.
// Reset clears both banks at once through row valid bits, selects bank a and
// loads the default masks; no clearing pass is needed.
// The result sits in an output register; a new command is taken once that
// register is empty or being emptied, so a stalled receiver holds off cmd.
// Off-grid positions give 0 and writes to them are dropped.
// Depends on llag_pkg, the three channel interfaces, llag_bank and llag_rule.
`include "life_like_automaton_grid_step_core_assert.svh"
module life_like_automaton_grid_step_core (
  input logic           clk,
  input logic           rst,
  llag_cmd_if.sink      cmd,
  llag_result_if.source result,
  llag_cfg_if.sink      cfg
);
  import llag_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_LOAD0,
    ST_LOAD1,
    ST_LOAD2,
    ST_ROW,
    ST_DONE
  } state_t;

  state_t                state;
  logic                  cur_bank;
  logic                  out_valid;
  logic                  out_alive;
  logic [MASK_W-1:0]     birth_mask;
  logic [MASK_W-1:0]     survive_mask;
  logic [COL_W-1:0]      x;
  logic [ROW_W-1:0]      y;
  logic [GRID_WIDTH-1:0] prev_row;
  logic [GRID_WIDTH-1:0] cur_row;
  logic [GRID_WIDTH-1:0] nxt_row;
  logic [GRID_WIDTH-1:0] ahead_row;
  logic [GRID_WIDTH-1:0] row_out;
  logic [COL_W-1:0]      req_col;
  logic [ROW_W-1:0]      req_row;
  logic                  req_on_grid;

  logic                  cmd_accept;
  op_t                   cmd_op;
  logic                  on_grid_in;
  logic [COL_W-1:0]      col_idx_in;
  logic [ROW_W-1:0]      row_idx_in;
  logic                  out_load;
  logic                  last_x;
  logic                  last_y;
  logic                  ahead_live;
  logic                  rd_en;
  logic [ROW_W-1:0]      rd_addr;
  logic                  wr_en;
  logic                  wr_bank;
  logic [ROW_W-1:0]      wr_addr;
  logic [GRID_WIDTH-1:0] wr_data;
  logic [GRID_WIDTH-1:0] wr_mask;
  logic [GRID_WIDTH-1:0] rdata_a;
  logic [GRID_WIDTH-1:0] rdata_b;
  logic [GRID_WIDTH-1:0] rdata_cur;
  logic [GRID_WIDTH+1:0] prev_pad;
  logic [GRID_WIDTH+1:0] cur_pad;
  logic [GRID_WIDTH+1:0] nxt_pad;
  logic                  cell_next;
  logic [GRID_WIDTH-1:0] row_out_next;
  rd_req_t               rd_a;
  rd_req_t               rd_b;
  wr_req_t               wr_a;
  wr_req_t               wr_b;

  // Handshake and decoded command fields.
  assign cmd.ready  = (state == ST_IDLE) && (!out_valid || result.ready);
  assign cmd_accept = cmd.valid && cmd.ready;
  assign cmd_op     = op_t'(cmd.op);
  assign on_grid_in = (int'(cmd.col) < GRID_WIDTH) && (int'(cmd.row) < GRID_HEIGHT);
  assign col_idx_in = COL_W'(cmd.col);
  assign row_idx_in = ROW_W'(cmd.row);
  assign cfg.ready  = 1'b1;

  // A result enters the output register on a write beat or at the end of a read or an advance.
  assign out_load = (state == ST_RD_WAIT) || (cmd_accept && cmd_op == OP_WRITE);

  assign result.valid     = out_valid;
  assign result.alive_out = out_alive;

  // Sweep position.
  assign last_x     = (x == COL_W'(GRID_WIDTH - 1));
  assign last_y     = (y == ROW_W'(GRID_HEIGHT - 1));
  assign ahead_live = (int'(y) + 2) < GRID_HEIGHT;

  // Reads always come from the current bank.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state)
      ST_IDLE: begin
        if (cmd_accept && cmd_op != OP_WRITE && cmd_op != OP_ADVANCE) begin
          rd_en   = 1'b1;
          rd_addr = row_idx_in;
        end
      end
      ST_LOAD0: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      ST_LOAD1: begin
        rd_en   = 1'b1;
        rd_addr = ROW_W'(1);
      end
      ST_ROW: begin
        if (x == '0 && ahead_live) begin
          rd_en   = 1'b1;
          rd_addr = ROW_W'(int'(y) + 2);
        end
      end
      ST_DONE: begin
        rd_en   = 1'b1;
        rd_addr = req_row;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Cell writes go to the current bank, finished rows to the other one.
  always_comb begin
    wr_en   = 1'b0;
    wr_bank = cur_bank;
    wr_addr = row_idx_in;
    wr_data = '0;
    wr_mask = '0;
    if (state == ST_IDLE) begin
      if (cmd_accept && cmd_op == OP_WRITE && on_grid_in) begin
        wr_en            = 1'b1;
        wr_mask[col_idx_in] = 1'b1;
        wr_data[col_idx_in] = cmd.alive_in;
      end
    end else if (state == ST_ROW && last_x) begin
      wr_en   = 1'b1;
      wr_bank = ~cur_bank;
      wr_addr = y;
      wr_data = row_out_next;
      wr_mask = '1;
    end
  end

  assign rd_a = '{en: rd_en && !cur_bank, addr: rd_addr};
  assign rd_b = '{en: rd_en &&  cur_bank, addr: rd_addr};
  assign wr_a = '{en: wr_en && !wr_bank, addr: wr_addr, data: wr_data, mask: wr_mask};
  assign wr_b = '{en: wr_en &&  wr_bank, addr: wr_addr, data: wr_data, mask: wr_mask};

  llag_bank u_bank_a (
    .clk   (clk),
    .rst   (rst),
    .rd    (rd_a),
    .wr    (wr_a),
    .rdata (rdata_a)
  );

  llag_bank u_bank_b (
    .clk   (clk),
    .rst   (rst),
    .rd    (rd_b),
    .wr    (wr_b),
    .rdata (rdata_b)
  );

  assign rdata_cur = cur_bank ? rdata_b : rdata_a;

  // Zero-padded window rows give dead cells past the left and right edges.
  assign prev_pad = {1'b0, prev_row, 1'b0};
  assign cur_pad  = {1'b0, cur_row, 1'b0};
  assign nxt_pad  = {1'b0, nxt_row, 1'b0};

  llag_rule u_rule (
    .win_top      (prev_pad[x +: 3]),
    .win_mid      (cur_pad[x +: 3]),
    .win_bot      (nxt_pad[x +: 3]),
    .birth_mask   (birth_mask),
    .survive_mask (survive_mask),
    .alive_next   (cell_next)
  );

  // Next-generation row with the current cell merged in.
  always_comb begin
    row_out_next    = row_out;
    row_out_next[x] = cell_next;
  end

  // Sequencer, window registers, configuration and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cur_bank     <= 1'b0;
      out_valid    <= 1'b0;
      birth_mask   <= BIRTH_RESET;
      survive_mask <= SURVIVE_RESET;
      x            <= '0;
      y            <= '0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          CFG_BIRTH:   birth_mask   <= cfg.data;
          CFG_SURVIVE: survive_mask <= cfg.data;
          default:     birth_mask   <= birth_mask;
        endcase
      end

      // The output register fills on a result and empties when the receiver takes it.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (cmd_accept) begin
            req_col     <= col_idx_in;
            req_row     <= row_idx_in;
            req_on_grid <= on_grid_in;
            case (cmd_op)
              OP_WRITE: begin
                out_alive <= on_grid_in & cmd.alive_in;
              end
              OP_ADVANCE: begin
                state <= ST_LOAD0;
              end
              default: begin
                state <= ST_RD_WAIT;
              end
            endcase
          end
        end
        ST_RD_WAIT: begin
          out_alive <= req_on_grid & rdata_cur[req_col];
          state     <= ST_IDLE;
        end
        ST_LOAD0: begin
          state <= ST_LOAD1;
        end
        ST_LOAD1: begin
          prev_row <= '0;
          cur_row  <= rdata_cur;
          state    <= ST_LOAD2;
        end
        ST_LOAD2: begin
          nxt_row <= rdata_cur;
          x       <= '0;
          y       <= '0;
          state   <= ST_ROW;
        end
        ST_ROW: begin
          row_out <= row_out_next;
          if (x == COL_W'(1)) begin
            ahead_row <= ahead_live ? rdata_cur : '0;
          end
          if (last_x) begin
            x        <= '0;
            prev_row <= cur_row;
            cur_row  <= nxt_row;
            nxt_row  <= ahead_row;
            if (last_y) begin
              cur_bank <= ~cur_bank;
              state    <= ST_DONE;
            end else begin
              y <= y + ROW_W'(1);
            end
          end else begin
            x <= x + COL_W'(1);
          end
        end
        ST_DONE: begin
          state <= ST_RD_WAIT;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The banks swap right after the last cell of a generation.
  `LLAG_ASSERT_NEXT(a_bank_swap, state == ST_ROW && last_x && last_y, cur_bank != $past(cur_bank), "bank did not swap at end of generation")
  // While a command is at work the output register stays empty.
  `LLAG_ASSERT_IMPL(a_busy_out_empty, state != ST_IDLE, !out_valid, "result pending while busy")
  // The bank that is not current is written only with a finished row.
  `LLAG_ASSERT_IMPL(a_dst_write_last, wr_en && wr_bank != cur_bank, state == ST_ROW && last_x, "stray write to next bank")

endmodule

@@ tb/tb_life_like_automaton_grid_step_core.sv @@
// Self-checking testbench for the life-like automaton grid step core.
// Depends on llag_pkg, the cmd, result and cfg channel interfaces, and the core.
`timescale 1ns / 100ps
module tb_life_like_automaton_grid_step_core;
  import llag_pkg::*;

  localparam int GRID_CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int ITEM_TARGET = 140;

  // Codes the package leaves unnamed: the spare op and the spare register slots.
  localparam logic [OP_W-1:0]      OP_UNUSED    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  // Keeps a shadow of both banks and the rule masks, and queues the cell value
  // every accepted command should return.
  class grid_scoreboard;
    typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
      logic             alive;
    } cell_expect_t;

    bit                cells [2][GRID_CELLS];
    bit                cur_bank;
    logic [MASK_W-1:0] birth_rule;
    logic [MASK_W-1:0] survive_rule;
    cell_expect_t      expected_cells[$];
    int                mismatches;
    int                checked;
    int                advances;

    function new();
      foreach (cells[b, i]) cells[b][i] = 1'b0;
      cur_bank     = 1'b0;
      birth_rule   = BIRTH_RESET;
      survive_rule = SURVIVE_RESET;
      mismatches   = 0;
      checked      = 0;
      advances     = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [MASK_W-1:0] value);
      case (idx)
        CFG_BIRTH:   birth_rule = value;
        CFG_SURVIVE: survive_rule = value;
        default: ;
      endcase
    endfunction

    function void note_command(logic [OP_W-1:0] op, logic [POS_W-1:0] c,
                               logic [POS_W-1:0] r, logic a);
      cell_expect_t e;
      bit           on_grid;
      int           n;
      int           nx;
      int           ny;
      on_grid = (c < GRID_WIDTH) && (r < GRID_HEIGHT);
      case (op)
        OP_WRITE: begin
          if (on_grid) cells[cur_bank][r * GRID_WIDTH + c] = a;
        end
        OP_ADVANCE: begin
          // Next generation goes into the idle bank; off-grid neighbors are dead.
          for (int y = 0; y < GRID_HEIGHT; y++) begin
            for (int x = 0; x < GRID_WIDTH; x++) begin
              n = 0;
              for (int dy = -1; dy <= 1; dy++) begin
                for (int dx = -1; dx <= 1; dx++) begin
                  nx = x + dx;
                  ny = y + dy;
                  if ((dx != 0 || dy != 0) && nx >= 0 && nx < GRID_WIDTH &&
                      ny >= 0 && ny < GRID_HEIGHT)
                    n += cells[cur_bank][ny * GRID_WIDTH + nx];
                end
              end
              cells[~cur_bank][y * GRID_WIDTH + x] =
                cells[cur_bank][y * GRID_WIDTH + x] ? survive_rule[n] : birth_rule[n];
            end
          end
          cur_bank = ~cur_bank;
          advances++;
        end
        default: ;
      endcase
      e.op    = op;
      e.col   = c;
      e.row   = r;
      e.alive = on_grid ? cells[cur_bank][r * GRID_WIDTH + c] : 1'b0;
      expected_cells.push_back(e);
    endfunction

    function void check_result(logic actual);
      cell_expect_t e;
      if (expected_cells.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected, expected none actual %0b",
                 $time, actual);
      end else begin
        e = expected_cells.pop_front();
        checked++;
        if (actual !== e.alive) begin
          mismatches++;
          $display("%0t: op %0d col %0d row %0d: alive_out expected %0b actual %0b",
                   $time, e.op, e.col, e.row, e.alive, actual);
        end
      end
    endfunction

    function int pending();
      return expected_cells.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  llag_cmd_if    cmd_if ();
  llag_result_if res_if ();
  llag_cfg_if    cfg_if ();

  life_like_automaton_grid_step_core dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_if.sink),
    .result (res_if.source),
    .cfg    (cfg_if.sink)
  );

  grid_scoreboard board;
  bit             steady_flow = 1'b0;
  int             commands_sent = 0;
  int             reg_writes = 0;

  always #10 clk = ~clk;

  // Record every beat on the three channels; commands before results.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)
        board.set_register(cfg_if.index, cfg_if.data);
      if (cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1)
        board.note_command(cmd_if.op, cmd_if.col, cmd_if.row, cmd_if.alive_in);
      if (res_if.valid === 1'b1 && res_if.ready === 1'b1)
        board.check_result(res_if.alive_out);
    end
  end

  // Result receiver: a random stall before each beat unless the flow is steady.
  initial begin : result_sink
    int stall;
    res_if.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!(res_if.valid === 1'b1 && res_if.ready === 1'b1));
      @(negedge clk);
    end
  end

  // Send one command beat; entered and left at a falling edge, valid left high.
  task automatic send_command(input logic [OP_W-1:0] op, input logic [POS_W-1:0] c,
                              input logic [POS_W-1:0] r, input logic a);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_if.valid    <= 1'b1;
    cmd_if.op       <= op;
    cmd_if.col      <= c;
    cmd_if.row      <= r;
    cmd_if.alive_in <= a;
    do @(posedge clk); while (cmd_if.ready !== 1'b1);
    @(negedge clk);
    commands_sent++;
  endtask

  // Stop sending and wait until every expected cell value has come back.
  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    while (board.pending() > 0) @(negedge clk);
  endtask

  // One register write beat, with valid dropped again before the task returns.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MASK_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
    reg_writes++;
  endtask

  // Pattern corner: the grid edges often, anywhere else otherwise.
  function automatic logic [POS_W-1:0] pick_base();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return POS_W'(GRID_WIDTH - 4);
      default: return POS_W'($urandom_range(0, GRID_WIDTH - 4));
    endcase
  endfunction

  // Seed a small window, step it one to three generations, then read it back.
  task automatic pattern_sequence();
    logic [POS_W-1:0] bc;
    logic [POS_W-1:0] br;
    bc = pick_base();
    br = pick_base();
    repeat ($urandom_range(2, 8))
      send_command(OP_WRITE, POS_W'(bc + $urandom_range(0, 3)),
                   POS_W'(br + $urandom_range(0, 3)), $urandom_range(0, 2) != 0);
    repeat ($urandom_range(1, 3))
      send_command(OP_ADVANCE, POS_W'(bc + $urandom_range(0, 3)),
                   POS_W'(br + $urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    repeat ($urandom_range(2, 5))
      send_command(($urandom_range(0, 3) == 0) ? OP_UNUSED : OP_READ,
                   POS_W'(bc + $urandom_range(0, 4)), POS_W'(br + $urandom_range(0, 4)),
                   1'($urandom_range(0, 1)));
  endtask

  // Idle point: new rule masks, and a new choice of steady or bursty flow.
  task automatic change_rules();
    drain_results();
    case ($urandom_range(0, 5))
      0: begin
        write_reg(CFG_BIRTH, BIRTH_RESET);
        write_reg(CFG_SURVIVE, SURVIVE_RESET);
      end
      1: begin
        write_reg(CFG_BIRTH, '0);
        write_reg(CFG_SURVIVE, '1);
      end
      2: begin
        write_reg(CFG_BIRTH, '1);
        write_reg(CFG_SURVIVE, '0);
      end
      3: begin
        write_reg(CFG_BIRTH, MASK_W'($urandom_range(0, 511)));
        write_reg(CFG_SURVIVE, MASK_W'($urandom_range(0, 511)));
      end
      4: write_reg(($urandom_range(0, 1) != 0) ? CFG_SURVIVE : CFG_BIRTH,
                   MASK_W'($urandom_range(0, 511)));
      default: begin
        write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO,
                  MASK_W'($urandom_range(0, 511)));
        write_reg(CFG_BIRTH, MASK_W'($urandom_range(0, 511)));
      end
    endcase
    steady_flow = ($urandom_range(0, 3) == 0);
  endtask

  initial begin : stimulus
    board = new();
    cmd_if.valid    = 1'b0;
    cmd_if.op       = OP_READ;
    cmd_if.col      = '0;
    cmd_if.row      = '0;
    cmd_if.alive_in = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = CFG_BIRTH;
    cfg_if.data     = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Cleared banks, then the spare op, which must read and not write.
    send_command(OP_READ, 0, 0, 0);
    send_command(OP_UNUSED, 63, 63, 1);
    send_command(OP_READ, 63, 63, 0);
    // A blinker against the left edge, and a cell written live then dead.
    send_command(OP_WRITE, 0, 0, 1);
    send_command(OP_WRITE, 0, 1, 1);
    send_command(OP_WRITE, 0, 2, 1);
    send_command(OP_WRITE, 63, 63, 1);
    send_command(OP_WRITE, 63, 63, 0);
    send_command(OP_ADVANCE, 1, 1, 0);
    // The far column stays dead because the grid does not wrap.
    send_command(OP_READ, 63, 1, 0);
    send_command(OP_READ, 0, 1, 0);
    send_command(OP_READ, 0, 0, 1);
    send_command(OP_ADVANCE, 0, 1, 1);
    send_command(OP_READ, 1, 1, 0);

    // Every dead cell born and every live cell dying.
    drain_results();
    write_reg(CFG_BIRTH, '1);
    write_reg(CFG_SURVIVE, '0);
    send_command(OP_ADVANCE, 5, 5, 0);
    send_command(OP_READ, 0, 0, 0);
    send_command(OP_UNUSED, 63, 63, 1);

    // Nothing born and everything alive kept.
    drain_results();
    write_reg(CFG_BIRTH, '0);
    write_reg(CFG_SURVIVE, '1);
    send_command(OP_ADVANCE, 63, 0, 0);
    send_command(OP_READ, 32, 32, 0);

    // Spare register slots must leave both masks alone.
    drain_results();
    write_reg(CFG_SPARE_LO, '1);
    write_reg(CFG_SPARE_HI, 9'h0AA);
    send_command(OP_ADVANCE, 1, 0, 0);
    drain_results();
    write_reg(CFG_BIRTH, BIRTH_RESET);
    write_reg(CFG_SURVIVE, SURVIVE_RESET);

    // Random part: mostly seeded windows, some noise, and rule changes.
    while (commands_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: change_rules();
        1, 2: begin
          repeat ($urandom_range(1, 4))
            send_command(OP_W'($urandom_range(0, 3)), POS_W'($urandom_range(0, 63)),
                         POS_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
        end
        default: pattern_sequence();
      endcase
    end

    drain_results();
    repeat (8) @(negedge clk);
    $display("Covered %0d commands with %0d generation steps and %0d register writes;",
             commands_sent, board.advances, reg_writes);
    $display("%0d result beats checked, %0d mismatches.", board.checked, board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin : watchdog
    #100_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, board.pending());
    $display("Test completed with failures");
    $finish;
  end

endmodule
